// File: hw/rtl/bpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpe_pkg;

    // Fixed field widths of the block's interface.
    localparam int COORD_W   = 16;
    localparam int T_IN_W    = 17;
    localparam int DEGREE_W  = 2;
    localparam int NUM_CTRL  = 4;
    localparam int CFG_IDX_W = 3;

    // Parameter value 1.0 in Q1.16.
    localparam logic [T_IN_W-1:0] T_ONE = 17'h10000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_3 = 3'd4;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [DEGREE_W-1:0]          degree;
        t_coord [NUM_CTRL-1:0]        ctrl;
    } t_cfg;

    // Control that travels with each word down the interpolation pipeline.
    typedef struct packed {
        logic                valid;
        logic [DEGREE_W-1:0] levels;
    } t_stage_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/bpe_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bpe_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bpe_pkg::COORD_W-1:0]   i_cfg_data,
    output bpe_pkg::t_cfg                      o_cfg
);

    bpe_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.degree <= bpe_pkg::DEGREE_W'(3);
            r_cfg.ctrl   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bpe_pkg::CFG_DEGREE: r_cfg.degree  <= i_cfg_data[bpe_pkg::DEGREE_W-1:0];
                bpe_pkg::CFG_CTRL_0: r_cfg.ctrl[0] <= i_cfg_data;
                bpe_pkg::CFG_CTRL_1: r_cfg.ctrl[1] <= i_cfg_data;
                bpe_pkg::CFG_CTRL_2: r_cfg.ctrl[2] <= i_cfg_data;
                bpe_pkg::CFG_CTRL_3: r_cfg.ctrl[3] <= i_cfg_data;
                default: begin
                    // Unknown index: the write is dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hw/rtl/bpe_lerp_stage.sv
`timescale 1ns / 1ps
`default_nettype none

// One de Casteljau level in two register stages: difference and magnitude
// first, then the multiply by t and the add back onto the base point.
module bpe_lerp_stage #(
    parameter  int MAX_DEGREE = 3,
    parameter  int FRAC_BITS  = 16,
    parameter  int LEVEL      = 1,
    localparam int NP         = MAX_DEGREE + 1,
    localparam int VW         = bpe_pkg::COORD_W + FRAC_BITS,
    localparam int TW         = FRAC_BITS + 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  bpe_pkg::t_stage_ctl          i_ctl,
    input  wire logic [NP-1:0][VW-1:0]   i_pts,
    input  wire logic [TW-1:0]           i_tf,
    output logic                         o_ready,
    output bpe_pkg::t_stage_ctl          o_ctl,
    output logic [NP-1:0][VW-1:0]        o_pts,
    output logic [TW-1:0]                o_tf,
    input  wire logic                    i_ready
);

    logic                          r_a_valid;
    logic [bpe_pkg::DEGREE_W-1:0]  r_a_levels;
    logic [NP-1:0][VW-1:0]         r_a_pts;
    logic [NP-2:0][VW-1:0]         r_a_mag;
    logic [NP-2:0]                 r_a_neg;
    logic [NP-2:0]                 r_a_act;
    logic [TW-1:0]                 r_a_tf;

    logic                          r_b_valid;
    logic [bpe_pkg::DEGREE_W-1:0]  r_b_levels;
    logic [NP-1:0][VW-1:0]         r_b_pts;
    logic [TW-1:0]                 r_b_tf;

    logic [NP-2:0][VW-1:0]         n_a_mag;
    logic [NP-2:0]                 n_a_neg;
    logic [NP-2:0]                 n_a_act;
    logic [NP-1:0][VW-1:0]         n_b_pts;

    logic                          w_rdy_a;
    logic                          w_rdy_b;

    assign w_rdy_b = !r_b_valid || i_ready;
    assign w_rdy_a = !r_a_valid || w_rdy_b;
    assign o_ready = w_rdy_a;

    // A lane is interpolated at this level only while it lies inside the
    // triangle for the configured degree; other lanes pass through.
    always_comb begin
        logic signed [VW:0] w_diff;
        for (int i = 0; i < NP - 1; i++) begin
            w_diff = $signed({i_pts[i+1][VW-1], i_pts[i+1]})
                   - $signed({i_pts[i][VW-1], i_pts[i]});
            n_a_neg[i] = w_diff[VW];
            n_a_mag[i] = w_diff[VW] ? VW'(-w_diff) : w_diff[VW-1:0];
            n_a_act[i] = int'(i_ctl.levels) >= (i + LEVEL);
        end
    end

    // Increment magnitude truncated to FRAC_BITS, then applied with the sign.
    always_comb begin
        logic [VW+TW-1:0] w_prod;
        logic [VW-1:0]    w_inc;
        for (int i = 0; i < NP - 1; i++) begin
            w_prod = (VW+TW)'(r_a_mag[i]) * (VW+TW)'(r_a_tf);
            w_inc  = w_prod[FRAC_BITS +: VW];
            if (!r_a_act[i]) begin
                n_b_pts[i] = r_a_pts[i];
            end else if (r_a_neg[i]) begin
                n_b_pts[i] = r_a_pts[i] - w_inc;
            end else begin
                n_b_pts[i] = r_a_pts[i] + w_inc;
            end
        end
        n_b_pts[NP-1] = r_a_pts[NP-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_valid <= i_ctl.valid;
            end
            if (w_rdy_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_ctl.valid) begin
            r_a_levels <= i_ctl.levels;
            r_a_pts    <= i_pts;
            r_a_mag    <= n_a_mag;
            r_a_neg    <= n_a_neg;
            r_a_act    <= n_a_act;
            r_a_tf     <= i_tf;
        end
        if (w_rdy_b && r_a_valid) begin
            r_b_levels <= r_a_levels;
            r_b_pts    <= n_b_pts;
            r_b_tf     <= r_a_tf;
        end
    end

    assign o_ctl.valid  = r_b_valid;
    assign o_ctl.levels = r_b_levels;
    assign o_pts        = r_b_pts;
    assign o_tf         = r_b_tf;

endmodule

`default_nettype wire

// File: hw/rtl/bezier_point_evaluator.sv
// Structure: two register stages per de Casteljau level, then one output register.
// Throughput: one word per cycle while the output side takes words; every stage has its
// own ready, so bubbles are squeezed out.
// Reset (synchronous, active low) empties the pipeline and sets degree to 3, controls to 0.
`timescale 1ns / 1ps
`default_nettype none

module bezier_point_evaluator #(
    parameter  int MAX_DEGREE = 3,
    parameter  int FRAC_BITS  = 16,
    localparam int NP         = MAX_DEGREE + 1,
    localparam int VW         = bpe_pkg::COORD_W + FRAC_BITS,
    localparam int TW         = FRAC_BITS + 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port; index 0 is degree, 1 to 4 are ctrl_0 to ctrl_3.
    input  wire logic                          i_cfg_we,
    input  wire logic [bpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bpe_pkg::COORD_W-1:0]   i_cfg_data,
    // Input stream.
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [23:0]                   i_s_tdata,  // [16:0] t_param, rest zero
    // Output stream.
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [15:0]                        o_m_tdata   // [15:0] coord
);

    bpe_pkg::t_cfg        w_cfg;

    // Pipeline links: index 0 is the input side, index k is the output of level k.
    bpe_pkg::t_stage_ctl  w_ctl [0:MAX_DEGREE];
    logic [NP-1:0][VW-1:0] w_pts [0:MAX_DEGREE];
    logic [TW-1:0]        w_tf  [0:MAX_DEGREE];
    logic                 w_rdy [0:MAX_DEGREE];

    logic [bpe_pkg::T_IN_W-1:0] w_t16;
    logic [bpe_pkg::COORD_W-1:0] n_coord;

    logic                 r_o_valid;
    logic [bpe_pkg::COORD_W-1:0] r_o_coord;

    bpe_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Parameters above 1.0 saturate to 1.0 before the conversion to Q1.FRAC_BITS.
    assign w_t16 = (i_s_tdata[16] && (|i_s_tdata[15:0])) ? bpe_pkg::T_ONE
                                                         : i_s_tdata[16:0];

    generate
        if (FRAC_BITS >= 16) begin : g_t_up
            assign w_tf[0] = TW'(w_t16) << (FRAC_BITS - 16);
        end else begin : g_t_down
            assign w_tf[0] = TW'(w_t16 >> (16 - FRAC_BITS));
        end
    endgenerate

    // Degrees beyond what the pipeline holds are capped; degree 0 makes every
    // level a pass-through, so the result is ctrl_0.
    assign w_ctl[0].valid  = i_s_tvalid;
    assign w_ctl[0].levels = (int'(w_cfg.degree) > MAX_DEGREE)
                           ? bpe_pkg::DEGREE_W'(MAX_DEGREE) : w_cfg.degree;

    // Control coordinates enter as integers scaled by 2^FRAC_BITS.
    always_comb begin
        for (int i = 0; i < NP; i++) begin
            w_pts[0][i] = {w_cfg.ctrl[i], {FRAC_BITS{1'b0}}};
        end
    end

    assign o_s_tready = w_rdy[0];

    genvar k;
    generate
        for (k = 1; k <= MAX_DEGREE; k++) begin : g_level
            bpe_lerp_stage #(
                .MAX_DEGREE (MAX_DEGREE),
                .FRAC_BITS  (FRAC_BITS),
                .LEVEL      (k)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[k-1]),
                .i_pts   (w_pts[k-1]),
                .i_tf    (w_tf[k-1]),
                .o_ready (w_rdy[k-1]),
                .o_ctl   (w_ctl[k]),
                .o_pts   (w_pts[k]),
                .o_tf    (w_tf[k]),
                .i_ready (w_rdy[k])
            );
        end
    endgenerate

    // The output register frees as soon as its word is taken, so a taken word
    // does not hold up the pipeline.
    assign w_rdy[MAX_DEGREE] = !r_o_valid || i_m_tready;

    // Truncation toward zero: arithmetic shift floors, so a negative value with
    // a nonzero fraction gets one added back.
    assign n_coord = w_pts[MAX_DEGREE][0][VW-1 -: bpe_pkg::COORD_W]
                   + bpe_pkg::COORD_W'(w_pts[MAX_DEGREE][0][VW-1]
                                       && (|w_pts[MAX_DEGREE][0][FRAC_BITS-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_rdy[MAX_DEGREE]) begin
            r_o_valid <= w_ctl[MAX_DEGREE].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[MAX_DEGREE] && w_ctl[MAX_DEGREE].valid) begin
            r_o_coord <= n_coord;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_coord;

`ifndef SYNTHESIS
    // Input back-pressure only arises when every stage is full behind a stalled output.
    a_ready_only_when_stalled: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready)
    ) else $error("input stalled while the output side was free");

    // Reset empties the output register.
    a_reset_clears_output: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid
    ) else $error("output valid after reset");

    // A new output word only comes from a valid word at the last level.
    a_output_from_last_level: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_ctl[MAX_DEGREE].valid)
    ) else $error("output word appeared without a valid last-level word");

    // The output register holds its word until it is taken.
    a_held_until_taken: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(r_o_coord))
    ) else $error("output word changed while stalled");
`endif

endmodule

`default_nettype wire

// File: test/bezier_coord_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the evaluator. It keeps
// its own copy of the curve registers, works out the coordinate for every
// accepted parameter word and compares each output word with the oldest
// outstanding prediction.
module bezier_coord_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bpe_pkg::COORD_W-1:0]   i_cfg_data,
    input  wire logic                          i_s_tvalid,
    input  wire logic                          i_s_tready,
    input  wire logic [23:0]                   i_s_tdata,  // [16:0] t_param, rest zero
    input  wire logic                          i_m_tvalid,
    input  wire logic                          i_m_tready,
    input  wire logic [15:0]                   i_m_tdata,  // [15:0] coord
    output int                                 o_fail_count,
    output int                                 o_pending
);

    localparam int FRAC = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [bpe_pkg::T_IN_W-1:0] t;
        bpe_pkg::t_coord            coord;
    } coord_exp_t;

    logic [bpe_pkg::DEGREE_W-1:0] degree_r;
    bpe_pkg::t_coord              ctrl_r [bpe_pkg::NUM_CTRL];
    coord_exp_t                   coord_exp_q [$];

    // De Casteljau in Q.16: each level moves a point toward its neighbor by
    // an increment truncated toward zero, and the result is truncated toward zero.
    function automatic bpe_pkg::t_coord bezier_coord(input logic [bpe_pkg::T_IN_W-1:0] t_raw);
        longint pt [bpe_pkg::NUM_CTRL];
        longint tf, d, mag, inc;
        int     levels, r, i;
        tf = (t_raw > bpe_pkg::T_ONE) ? longint'(bpe_pkg::T_ONE) : longint'(t_raw);
        levels = int'(degree_r);
        for (i = 0; i < bpe_pkg::NUM_CTRL; i++)
            pt[i] = longint'(ctrl_r[i]) * (longint'(1) << FRAC);
        for (r = 1; r <= levels; r++) begin
            for (i = 0; i + r <= levels; i++) begin
                d   = pt[i + 1] - pt[i];
                mag = (d < 0) ? -d : d;
                inc = (mag * tf) >> FRAC;
                pt[i] = (d < 0) ? pt[i] - inc : pt[i] + inc;
            end
        end
        if (pt[0] < 0)
            return bpe_pkg::t_coord'(-((-pt[0]) >> FRAC));
        return bpe_pkg::t_coord'(pt[0] >> FRAC);
    endfunction

    task automatic note_fail(input string msg);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS)
            $display("%0t ns: coord check failed: %s", $time, msg);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        coord_exp_t want;
        if (!i_rst_n) begin
            degree_r = 2'd3;
            foreach (ctrl_r[k])
                ctrl_r[k] = '0;
            coord_exp_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bpe_pkg::CFG_DEGREE: degree_r  = i_cfg_data[bpe_pkg::DEGREE_W-1:0];
                    bpe_pkg::CFG_CTRL_0: ctrl_r[0] = i_cfg_data;
                    bpe_pkg::CFG_CTRL_1: ctrl_r[1] = i_cfg_data;
                    bpe_pkg::CFG_CTRL_2: ctrl_r[2] = i_cfg_data;
                    bpe_pkg::CFG_CTRL_3: ctrl_r[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                want.t     = i_s_tdata[bpe_pkg::T_IN_W-1:0];
                want.coord = bezier_coord(want.t);
                coord_exp_q.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (coord_exp_q.size() == 0) begin
                    note_fail($sformatf("unexpected word %0d",
                                        $signed(i_m_tdata)));
                end else begin
                    want = coord_exp_q.pop_front();
                    if ($signed(i_m_tdata) !== want.coord)
                        note_fail($sformatf("t=0x%05h expected %0d, got %0d",
                                            want.t, want.coord, $signed(i_m_tdata)));
                end
            end
        end
        o_pending = coord_exp_q.size();
    end

endmodule

// File: test/bezier_point_evaluator_tb.sv
`timescale 1ns / 1ps

// Testbench for the cubic Bezier coordinate evaluator. It loads a series of
// curves through the configuration port and streams curve parameters in,
// while the checker beside the block predicts every coordinate and compares
// it with the block's output words. The run starts with hand-picked corner
// cases and continues with random curves and parameters under three
// back-pressure regimes.
module bezier_point_evaluator_tb;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_WORDS = 1250;
    localparam int HOLD_CYCLES  = 64;     // long receiver hold-off to fill the pipeline
    localparam int DRAIN_CYCLES = 20;     // room for any stray word to show up before the verdict
    localparam int RUN_LIMIT_NS = 3_000_000;

    // Highest index the configuration port can address; everything above
    // CFG_CTRL_3 must be ignored by the block.
    localparam logic [bpe_pkg::CFG_IDX_W-1:0] CFG_IDX_MAX = '1;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [bpe_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bpe_pkg::COORD_W-1:0]   cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [23:0]                   s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [15:0]                   m_tdata;
    int                            fail_count;
    int                            coords_pending;

    // Idle chances in percent for the sender and the receiver.
    int                            tx_idle_pct;
    int                            rx_idle_pct;
    // Set by the stimulus to make the receiver hold off for HOLD_CYCLES.
    logic                          rx_hold_req;

    // Parameter values that hit the ends of the range, the saturation above
    // 1.0 and both alternating bit patterns.
    logic [bpe_pkg::T_IN_W-1:0] t_corner [9] = '{
        17'h00000, 17'h00001, 17'h08000, 17'h0ffff, bpe_pkg::T_ONE,
        17'h10001, 17'h1ffff, 17'h0aaaa, 17'h15555
    };

    bezier_point_evaluator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    bezier_coord_checker coord_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (coords_pending)
    );

    always begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // One register write per cycle. The caller lowers the write enable after
    // the last write of a batch, so the enable never toggles within one step.
    task automatic cfg_write(input logic [bpe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpe_pkg::COORD_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // Loads a whole curve. Only the low two bits of the degree word count,
    // so the random part puts noise into the upper bits.
    task automatic load_curve(input logic [15:0] degree_word,
                              input bpe_pkg::t_coord c0, input bpe_pkg::t_coord c1,
                              input bpe_pkg::t_coord c2, input bpe_pkg::t_coord c3);
        cfg_write(bpe_pkg::CFG_DEGREE, degree_word);
        cfg_write(bpe_pkg::CFG_CTRL_0, c0);
        cfg_write(bpe_pkg::CFG_CTRL_1, c1);
        cfg_write(bpe_pkg::CFG_CTRL_2, c2);
        cfg_write(bpe_pkg::CFG_CTRL_3, c3);
        cfg_we <= 1'b0;
    endtask

    // Offers one parameter word and returns at the rising edge that takes
    // it. The next call decides at the following falling edge whether
    // valid stays up, so valid is assigned once per step.
    task automatic push_t(input logic [bpe_pkg::T_IN_W-1:0] t);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, t};
        do @(posedge clk); while (!s_tready);
    endtask

    // Stops offering and waits until every predicted coordinate has arrived,
    // which also leaves the block idle for the next register writes.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (coords_pending == 0);
        @(negedge clk);
    endtask

    function automatic logic [bpe_pkg::T_IN_W-1:0] rand_t();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return t_corner[$urandom_range(4)];
        else if (roll < 25)
            return bpe_pkg::T_IN_W'($urandom_range(17'h1ffff, 17'h10001));
        return bpe_pkg::T_IN_W'($urandom_range(bpe_pkg::T_ONE, 0));
    endfunction

    function automatic bpe_pkg::t_coord rand_ctrl();
        case ($urandom_range(9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return bpe_pkg::t_coord'($urandom);
        endcase
    endfunction

    // Receiver side: random ready, with one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        int sent, phase_len, n, k;
        bit hold_done;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        rx_hold_req = 1'b0;
        tx_idle_pct = 25;
        rx_idle_pct = 85;
        hold_done   = 1'b0;
        sent        = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Reset curve: degree 3 with all controls at zero.
        push_t(t_corner[0]);
        push_t(bpe_pkg::T_ONE);
        settle();

        // Full-swing cubic: largest differences between neighbors, all
        // parameter corners including values above 1.0.
        load_curve(16'd3, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        foreach (t_corner[i])
            push_t(t_corner[i]);
        settle();

        // Degree 0 returns ctrl_0 whatever t is.
        load_curve(16'd0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        push_t(t_corner[2]);
        push_t(bpe_pkg::T_ONE);
        push_t(t_corner[6]);
        settle();

        // Linear and quadratic curves; the unused controls are set to the
        // opposite extreme so that any leak shows up.
        load_curve(16'd1, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        push_t(t_corner[1]);
        push_t(t_corner[7]);
        push_t(t_corner[4]);
        settle();
        load_curve(16'd2, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        push_t(t_corner[3]);
        push_t(t_corner[8]);
        push_t(t_corner[2]);
        settle();

        // Writes to addresses past the last control must change nothing.
        for (k = bpe_pkg::CFG_CTRL_3 + 1; k <= CFG_IDX_MAX; k++)
            cfg_write(bpe_pkg::CFG_IDX_W'(k), 16'hffff);
        cfg_we <= 1'b0;
        push_t(t_corner[7]);
        push_t(t_corner[8]);
        settle();

        // Random curves, each followed by a burst of parameters. The first
        // third runs with a slow receiver, the second with a slow sender and
        // the last at full rate, opening with the long receiver hold-off.
        while (sent < RANDOM_WORDS) begin
            phase_len = $urandom_range(80, 20);
            if (sent >= 2 * RANDOM_WORDS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                if (!hold_done) begin
                    hold_done   = 1'b1;
                    rx_hold_req = 1'b1;
                    phase_len   = 120;
                end
            end else if (sent >= RANDOM_WORDS / 3) begin
                tx_idle_pct = 85;
                rx_idle_pct = 25;
            end
            load_curve(16'($urandom), rand_ctrl(), rand_ctrl(), rand_ctrl(), rand_ctrl());
            if ($urandom_range(7) == 0) begin
                // Step past the edge where the curve load lowered the enable.
                @(negedge clk);
                cfg_write(bpe_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_MAX,
                                                             bpe_pkg::CFG_CTRL_3 + 1)),
                          16'($urandom));
                cfg_we <= 1'b0;
            end
            for (n = 0; n < phase_len; n++)
                push_t(rand_t());
            sent += phase_len;
            settle();
        end

        // Give any stray word time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[bezier_point_evaluator] OK");
        else
            $display("[bezier_point_evaluator] ERROR");
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin
        #RUN_LIMIT_NS;
        $display("[bezier_point_evaluator] ERROR");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/bpe_pkg.sv
hw/rtl/bpe_cfg_regs.sv
hw/rtl/bpe_lerp_stage.sv
hw/rtl/bezier_point_evaluator.sv
test/bezier_coord_checker.sv
test/bezier_point_evaluator_tb.sv
